FILE: hdl/sdsf_pkg.sv
// Shared types, register codes and the gain table of the stereo DAC sample formatter.
package sdsf_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned GAIN_W   = 30;
    localparam int unsigned GAIN_SHIFT = 29;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTEN_LEFT_DB  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTEN_RIGHT_DB = 2'd3;

    // Output mode codes; code three behaves as plain
    localparam logic [1:0] MODE_PLAIN      = 2'd0;
    localparam logic [1:0] MODE_INTERLEAVE = 2'd1;
    localparam logic [1:0] MODE_DUAL       = 2'd2;

    // Sample width codes; code three behaves as 32 bits
    localparam logic [1:0] WIDTH_16 = 2'd0;
    localparam logic [1:0] WIDTH_24 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } t_pair;

    // Q29 gain for whole-dB attenuation; above 100 dB hold the last step
    function automatic logic [31:0] gain_of(input logic [6:0] atten);
        logic [31:0] g;
        case (atten)
            7'd0: g = 32'h20000000; 7'd1: g = 32'h1c8520af; 7'd2: g = 32'h196b230b;
            7'd3: g = 32'h16a77dea; 7'd4: g = 32'h1430cd74; 7'd5: g = 32'h11feb33c;
            7'd6: g = 32'h1009b9cf; 7'd7: g = 32'h0e4b3b63; 7'd8: g = 32'h0cbd4b3f;
            7'd9: g = 32'h0b5aa19b; 7'd10: g = 32'h0a1e89b1; 7'd11: g = 32'h0904d1bd;
            7'd12: g = 32'h0809bcc3; 7'd13: g = 32'h0729f5d9; 7'd14: g = 32'h066284d5;
            7'd15: g = 32'h05b0c438; 7'd16: g = 32'h05125831; 7'd17: g = 32'h04852697;
            7'd18: g = 32'h04074fcb; 7'd19: g = 32'h03972853; 7'd20: g = 32'h03333333;
            7'd21: g = 32'h02da1cde; 7'd22: g = 32'h028ab6b4; 7'd23: g = 32'h0243f2fd;
            7'd24: g = 32'h0204e158; 7'd25: g = 32'h01ccab86; 7'd26: g = 32'h019a9294;
            7'd27: g = 32'h016dec56; 7'd28: g = 32'h0146211f; 7'd29: g = 32'h0122a9c2;
            7'd30: g = 32'h01030dc4; 7'd31: g = 32'h00e6e1c6; 7'd32: g = 32'h00cdc613;
            7'd33: g = 32'h00b76562; 7'd34: g = 32'h00a373ae; 7'd35: g = 32'h0091ad38;
            7'd36: g = 32'h0081d59e; 7'd37: g = 32'h0073b70f; 7'd38: g = 32'h00672194;
            7'd39: g = 32'h005bea6e; 7'd40: g = 32'h0051eb85; 7'd41: g = 32'h004902e3;
            7'd42: g = 32'h00411245; 7'd43: g = 32'h0039feb2; 7'd44: g = 32'h0033b022;
            7'd45: g = 32'h002e1127; 7'd46: g = 32'h00290ea8; 7'd47: g = 32'h002497a2;
            7'd48: g = 32'h00209ce9; 7'd49: g = 32'h001d10f9; 7'd50: g = 32'h0019e7c6;
            7'd51: g = 32'h00171693; 7'd52: g = 32'h001493ce; 7'd53: g = 32'h001256f0;
            7'd54: g = 32'h0010585e; 7'd55: g = 32'h000e9152; 7'd56: g = 32'h000cfbc3;
            7'd57: g = 32'h000b924e; 7'd58: g = 32'h000a5028; 7'd59: g = 32'h0009310b;
            7'd60: g = 32'h00083126; 7'd61: g = 32'h00074d16; 7'd62: g = 32'h000681d3;
            7'd63: g = 32'h0005ccab; 7'd64: g = 32'h00052b36; 7'd65: g = 32'h00049b50;
            7'd66: g = 32'h00041b10; 7'd67: g = 32'h0003a8c3; 7'd68: g = 32'h000342e4;
            7'd69: g = 32'h0002e818; 7'd70: g = 32'h0002972d; 7'd71: g = 32'h00024f0e;
            7'd72: g = 32'h00020ec7; 7'd73: g = 32'h0001d57e; 7'd74: g = 32'h0001a26f;
            7'd75: g = 32'h000174ee; 7'd76: g = 32'h00014c60; 7'd77: g = 32'h0001283b;
            7'd78: g = 32'h00010804; 7'd79: g = 32'h0000eb4d; 7'd80: g = 32'h0000d1b7;
            7'd81: g = 32'h0000bae8; 7'd82: g = 32'h0000a695; 7'd83: g = 32'h00009477;
            7'd84: g = 32'h00008452; 7'd85: g = 32'h000075ee; 7'd86: g = 32'h0000691b;
            7'd87: g = 32'h00005dad; 7'd88: g = 32'h0000537d; 7'd89: g = 32'h00004a68;
            7'd90: g = 32'h00004251; 7'd91: g = 32'h00003b1b; 7'd92: g = 32'h000034ad;
            7'd93: g = 32'h00002ef3; 7'd94: g = 32'h000029d7; 7'd95: g = 32'h0000254b;
            7'd96: g = 32'h0000213c; 7'd97: g = 32'h00001d9f; 7'd98: g = 32'h00001a66;
            7'd99: g = 32'h00001787;
            default: g = 32'h000014f8;
        endcase
        return g;
    endfunction

    // Bit-interleave two halves: a bit i to 2i+1, b bit i to 2i
    function automatic logic [31:0] weave(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] w;
        for (int i = 0; i < 16; i++) begin
            w[2*i+1] = a[i];
            w[2*i]   = b[i];
        end
        return w;
    endfunction

    // Two's complement negate, most negative value clamps to the maximum
    function automatic logic [31:0] negate_sat(input logic [31:0] x);
        logic [31:0] r;
        if (x == 32'h80000000) begin
            r = 32'h7fffffff;
        end else begin
            r = 32'd0 - x;
        end
        return r;
    endfunction

endpackage

FILE: hdl/sdsf_if.sv
// Valid/ready channel interfaces for frames in and DAC words out.
interface sdsf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_raw;
    logic [31:0] right_raw;
    modport source (output valid, output left_raw, output right_raw, input ready);
    modport sink   (input valid, input left_raw, input right_raw, output ready);
endinterface

interface sdsf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        last;
    modport source (output valid, output word, output last, input ready);
    modport sink   (input valid, input word, input last, output ready);
endinterface

FILE: hdl/stereo_dac_sample_formatter.sv
// Each frame gives two words in plain and interleaved modes, four in dual
// mode; the single output port sets the frame rate. The input side keeps
// accepting while the scale stages have room, and stalls once they fill
// behind a frame whose words are still being emitted.
// Reset (synchronous, active low) clears all valid flags and sets the
// registers to plain mode, 16-bit samples and 0 dB on both channels.
module stereo_dac_sample_formatter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sdsf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sdsf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    sdsf_in_if.sink                             i_sample,
    sdsf_out_if.source                          o_word
);

    // Configuration registers
    logic [1:0] r_output_mode;
    logic [1:0] r_sample_width;
    logic [6:0] r_atten_left;
    logic [6:0] r_atten_right;

    // Scaled pair handed from the multiply stages to the word sequencer
    logic            pair_valid;
    logic            pair_ready;
    sdsf_pkg::t_pair pair;

    // Write a register when the enable is high; mode and width keep only the low two bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_mode  <= sdsf_pkg::MODE_PLAIN;
            r_sample_width <= sdsf_pkg::WIDTH_16;
            r_atten_left   <= 7'd0;
            r_atten_right  <= 7'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sdsf_pkg::CFG_OUTPUT_MODE:    r_output_mode  <= i_cfg_data[1:0];
                sdsf_pkg::CFG_SAMPLE_WIDTH:   r_sample_width <= i_cfg_data[1:0];
                sdsf_pkg::CFG_ATTEN_LEFT_DB:  r_atten_left   <= i_cfg_data;
                sdsf_pkg::CFG_ATTEN_RIGHT_DB: r_atten_right  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Align and scale both channels: input register, then product register
    sdsf_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_sample.valid),
        .o_ready        (i_sample.ready),
        .i_left_raw     (i_sample.left_raw),
        .i_right_raw    (i_sample.right_raw),
        .i_sample_width (r_sample_width),
        .i_atten_left   (r_atten_left),
        .i_atten_right  (r_atten_right),
        .o_valid        (pair_valid),
        .i_ready        (pair_ready),
        .o_pair         (pair)
    );

    // Emit plain, interleaved or dual word sequences; flag the final word
    sdsf_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (pair_valid),
        .o_ready       (pair_ready),
        .i_pair        (pair),
        .i_output_mode (r_output_mode),
        .o_out         (o_word)
    );

endmodule

FILE: hdl/sdsf_scale.sv
// Align raw samples, look up gains, then multiply and shift in two register stages.
module sdsf_scale (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [31:0]           i_left_raw,
    input  logic [31:0]           i_right_raw,
    input  logic [1:0]            i_sample_width,
    input  logic [6:0]            i_atten_left,
    input  logic [6:0]            i_atten_right,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sdsf_pkg::t_pair       o_pair
);

    logic                          r_s1_valid;
    logic [sdsf_pkg::SAMPLE_W-1:0] r_s1_left;
    logic [sdsf_pkg::SAMPLE_W-1:0] r_s1_right;
    logic [sdsf_pkg::GAIN_W-1:0]   r_s1_gain_l;
    logic [sdsf_pkg::GAIN_W-1:0]   r_s1_gain_r;
    logic                          r_s2_valid;
    sdsf_pkg::t_pair               r_s2_pair;

    logic [31:0] n_align_l;
    logic [31:0] n_align_r;
    logic [31:0] gain_full_l;
    logic [31:0] gain_full_r;
    logic signed [62:0] prod_l;
    logic signed [62:0] prod_r;
    logic s2_load;
    logic s1_load;

    function automatic logic [31:0] align(input logic [31:0] raw, input logic [1:0] wcode);
        logic [31:0] a;
        unique case (wcode)
            sdsf_pkg::WIDTH_16: a = {raw[15:0], 16'h0000};
            sdsf_pkg::WIDTH_24: a = {raw[23:0], 8'h00};
            default:            a = raw;
        endcase
        return a;
    endfunction

    always_comb begin
        n_align_l   = align(i_left_raw, i_sample_width);
        n_align_r   = align(i_right_raw, i_sample_width);
        gain_full_l = sdsf_pkg::gain_of(i_atten_left);
        gain_full_r = sdsf_pkg::gain_of(i_atten_right);
    end

    // Signed sample times non-negative gain; keep product bits 60..29
    assign prod_l = $signed(r_s1_left) * $signed({1'b0, r_s1_gain_l});
    assign prod_r = $signed(r_s1_right) * $signed({1'b0, r_s1_gain_r});

    assign s2_load = !r_s2_valid || i_ready;
    assign s1_load = !r_s1_valid || s2_load;
    assign o_ready = s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= i_valid;
            end
            if (s2_load) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_valid) begin
            r_s1_left   <= n_align_l;
            r_s1_right  <= n_align_r;
            r_s1_gain_l <= gain_full_l[sdsf_pkg::GAIN_W-1:0];
            r_s1_gain_r <= gain_full_r[sdsf_pkg::GAIN_W-1:0];
        end
        if (s2_load && r_s1_valid) begin
            r_s2_pair.left  <= prod_l[60:29];
            r_s2_pair.right <= prod_r[60:29];
        end
    end

    assign o_valid = r_s2_valid;
    assign o_pair  = r_s2_pair;

endmodule

FILE: hdl/sdsf_emit.sv
// Sequence two or four DAC words per scaled pair through one output register.
module sdsf_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sdsf_pkg::t_pair i_pair,
    input  logic [1:0]      i_output_mode,
    sdsf_out_if.source      o_out
);

    sdsf_pkg::t_pair r_pair;
    logic [1:0]      r_idx;
    logic            r_valid;
    logic [31:0]     r_word;
    logic            r_last;

    logic            load;
    logic            step;
    logic [1:0]      n_idx;
    sdsf_pkg::t_pair sel_pair;
    logic [31:0]     n_word;
    logic            n_last;
    logic [31:0]     neg_l;
    logic [31:0]     neg_r;

    assign o_ready = !r_valid || (o_out.ready && r_last);
    assign load    = o_ready && i_valid;
    assign step    = r_valid && o_out.ready && !r_last;

    always_comb begin
        sel_pair = load ? i_pair : r_pair;
        n_idx    = load ? 2'd0 : r_idx + 2'd1;
        neg_l    = sdsf_pkg::negate_sat(sel_pair.left);
        neg_r    = sdsf_pkg::negate_sat(sel_pair.right);
        n_last   = (n_idx == 2'd1);
        case (i_output_mode) inside
            sdsf_pkg::MODE_INTERLEAVE, sdsf_pkg::MODE_DUAL: begin
                case (n_idx)
                    2'd0:    n_word = sdsf_pkg::weave(sel_pair.left[15:0], sel_pair.right[15:0]);
                    2'd1:    n_word = sdsf_pkg::weave(sel_pair.left[31:16],
                                                      sel_pair.right[31:16]);
                    2'd2:    n_word = sdsf_pkg::weave(neg_l[15:0], neg_r[15:0]);
                    default: n_word = sdsf_pkg::weave(neg_l[31:16], neg_r[31:16]);
                endcase
                if (i_output_mode == sdsf_pkg::MODE_DUAL) begin
                    n_last = (n_idx == 2'd3);
                end
            end
            default: begin
                n_word = (n_idx == 2'd0) ? sel_pair.left : sel_pair.right;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= r_valid && !r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pair <= i_pair;
        end
        if (load || step) begin
            r_idx  <= n_idx;
            r_word <= n_word;
            r_last <= n_last;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.word  = r_word;
    assign o_out.last  = r_last;

endmodule
